/* src/sbq_pkg.sv */
// ----------------------------------------------------------------------------
// sbq_pkg: shared types and constants for the stereo biquad filter
// Word formats, configuration register indexes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbq_pkg;

    // fixed formats
    localparam int COEF_BITS  = 32;
    localparam int STATE_BITS = 48;
    localparam int CHANNELS   = 2;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // defaults for the top level parameters
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 30;

    // configuration register indexes
    localparam int IDX_W = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_B0 = 3'd0,
        REG_COEF_B1 = 3'd1,
        REG_COEF_B2 = 3'd2,
        REG_COEF_A1 = 3'd3,
        REG_COEF_A2 = 3'd4
    } cfg_idx_t;

    // coefficient feeding the shared multiplier
    typedef enum logic [2:0] {
        SEL_B0,
        SEL_B1,
        SEL_B2,
        SEL_A1,
        SEL_A2
    } coef_sel_t;

    // controller states: one per step of a channel, plus idle and hand-over
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_ACC,
        ST_ROUND,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic            capture;
        logic            mul_en;
        coef_sel_t       coef_sel;
        logic            use_y;
        logic            acc_load;
        logic            y_load;
        logic            t_load;
        logic            u_load;
        logic            t_sub;
        logic            state_write;
        logic            out_load;
        logic [CH_W-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

/* src/sbq_ctrl.sv */
// ----------------------------------------------------------------------------
// sbq_ctrl: sequencer for the stereo biquad filter
// Steps every channel through six steps of multiply and accumulate, then
// hands the finished word to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sbq_pkg::status_t status,
    output sbq_pkg::cmd_t    cmd
);
    import sbq_pkg::*;

    state_t          state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;

    // state and channel registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    ch_next     = '0;
                    state_next  = ST_MUL_B0;
                end
            end
            ST_MUL_B0:
            begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = SEL_B0;
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = SEL_B1;
                cmd.acc_load = 1'b1;
                state_next   = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = SEL_B2;
                cmd.y_load   = 1'b1;
                cmd.t_load   = 1'b1;
                state_next   = ST_MUL_A1;
            end
            ST_MUL_A1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = SEL_A1;
                cmd.use_y    = 1'b1;
                cmd.u_load   = 1'b1;
                state_next   = ST_MUL_A2;
            end
            ST_MUL_A2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.coef_sel = SEL_A2;
                cmd.use_y    = 1'b1;
                cmd.t_sub    = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.state_write = 1'b1;
                if (ch_reg == CH_W'(CHANNELS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_MUL_B0;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/sbq_datapath.sv */
// ----------------------------------------------------------------------------
// sbq_datapath: arithmetic and storage for the stereo biquad filter
// Coefficient registers, one shared multiplier, accumulators, per-channel
// delay registers and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbq_datapath #(
    parameter int SAMPLE_BITS    = sbq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [sbq_pkg::IDX_W-1:0]     wr_index,
    input  logic [sbq_pkg::COEF_BITS-1:0] wr_data,
    input  logic signed [SAMPLE_BITS-1:0] x_in [sbq_pkg::CHANNELS],
    input  sbq_pkg::cmd_t                 cmd,
    output sbq_pkg::status_t              status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] y_out [sbq_pkg::CHANNELS]
);
    import sbq_pkg::*;

    localparam int STATE_FRAC = STATE_BITS - 3 - SAMPLE_BITS;
    localparam int SHIFT_D    = STATE_FRAC - COEF_FRAC_BITS;
    localparam int SHIFT_L    = (SHIFT_D > 0) ? SHIFT_D : 0;
    localparam int SHIFT_R    = (SHIFT_D < 0) ? -SHIFT_D : 0;
    localparam int PROD_W     = COEF_BITS + SAMPLE_BITS;
    localparam int SP_W       = PROD_W + SHIFT_L + 1;
    localparam int SUM_W      = ((SP_W > STATE_BITS) ? SP_W : STATE_BITS) + 2;
    localparam int RND_W      = STATE_BITS + 1;
    localparam int Q_W        = RND_W - STATE_FRAC;

    logic signed [COEF_BITS-1:0]   b0_reg, b0_next, b1_reg, b1_next, b2_reg, b2_next;
    logic signed [COEF_BITS-1:0]   a1_reg, a1_next, a2_reg, a2_next;
    logic signed [SAMPLE_BITS-1:0] x_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] x_next [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] res_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] res_next [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] out_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] out_next [CHANNELS];
    logic signed [STATE_BITS-1:0]  fd_reg [CHANNELS];
    logic signed [STATE_BITS-1:0]  fd_next [CHANNELS];
    logic signed [STATE_BITS-1:0]  sd_reg [CHANNELS];
    logic signed [STATE_BITS-1:0]  sd_next [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [STATE_BITS-1:0]  acc_reg, acc_next;
    logic signed [SUM_W-1:0]       t_reg, t_next, u_reg, u_next;
    logic                          out_valid_reg, out_valid_next;

    logic signed [COEF_BITS-1:0]   mul_coef;
    logic signed [SAMPLE_BITS-1:0] mul_smp;
    logic signed [SP_W-1:0]        prod_ext, sp;
    logic signed [SUM_W-1:0]       sp_ext, fd_ext, sd_ext;
    logic signed [RND_W-1:0]       rnd;
    logic signed [Q_W-1:0]         q;
    logic [Q_W-SAMPLE_BITS:0]      q_top;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    // clamp a wide sum to the signed state range
    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-STATE_BITS:0]    top;
        logic signed [STATE_BITS-1:0] r;
        top = v[SUM_W-1:STATE_BITS-1];
        if ((&top) || !(|top))
        begin
            r = v[STATE_BITS-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(STATE_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration writes; unknown indexes drop
    always_comb
    begin
        b0_next = b0_reg;
        b1_next = b1_reg;
        b2_next = b2_reg;
        a1_next = a1_reg;
        a2_next = a2_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_COEF_B0: b0_next = wr_data;
                REG_COEF_B1: b1_next = wr_data;
                REG_COEF_B2: b2_next = wr_data;
                REG_COEF_A1: a1_next = wr_data;
                REG_COEF_A2: a2_next = wr_data;
                default: ;
            endcase
        end
    end

    // multiplier operands
    always_comb
    begin
        unique case (cmd.coef_sel)
            SEL_B0:  mul_coef = b0_reg;
            SEL_B1:  mul_coef = b1_reg;
            SEL_B2:  mul_coef = b2_reg;
            SEL_A1:  mul_coef = a1_reg;
            SEL_A2:  mul_coef = a2_reg;
            default: mul_coef = b0_reg;
        endcase
        mul_smp = cmd.use_y ? y_reg : x_reg[cmd.ch];
    end

    assign prod_next = cmd.mul_en ? (mul_coef * mul_smp) : prod_reg;

    // move the registered product to state scaling
    assign prod_ext = SP_W'(prod_reg);

    generate
        if (SHIFT_R > 0)
        begin : g_shift_right
            localparam logic signed [SP_W-1:0] HALF = SP_W'(1) <<< (SHIFT_R - 1);
            assign sp = (prod_ext + HALF) >>> SHIFT_R;
        end
        else
        begin : g_shift_left
            assign sp = prod_ext <<< SHIFT_L;
        end
    endgenerate

    assign sp_ext = SUM_W'(sp);
    assign fd_ext = SUM_W'(fd_reg[cmd.ch]);
    assign sd_ext = SUM_W'(sd_reg[cmd.ch]);

    // round the accumulator to a sample and saturate
    always_comb
    begin
        rnd   = RND_W'(acc_reg) + (RND_W'(1) <<< (STATE_FRAC - 1));
        q     = rnd[RND_W-1:STATE_FRAC];
        q_top = q[Q_W-1:SAMPLE_BITS-1];
        if ((&q_top) || !(|q_top))
        begin
            y_sat = q[SAMPLE_BITS-1:0];
        end
        else if (q[Q_W-1])
        begin
            y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // accumulators
    always_comb
    begin
        acc_next = cmd.acc_load ? sat_state(sp_ext + fd_ext) : acc_reg;
        y_next   = cmd.y_load ? y_sat : y_reg;
        u_next   = cmd.u_load ? sp_ext : u_reg;
        t_next   = t_reg;
        if (cmd.t_load)
        begin
            t_next = sp_ext;
        end
        else if (cmd.t_sub)
        begin
            t_next = t_reg - sp_ext;
        end
    end

    // per-channel words: input capture, results, delays, output
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            x_next[c]   = cmd.capture ? x_in[c] : x_reg[c];
            res_next[c] = res_reg[c];
            fd_next[c]  = fd_reg[c];
            sd_next[c]  = sd_reg[c];
            out_next[c] = cmd.out_load ? res_reg[c] : out_reg[c];
            if (cmd.y_load && (cmd.ch == CH_W'(c)))
            begin
                res_next[c] = y_sat;
            end
            if (cmd.state_write && (cmd.ch == CH_W'(c)))
            begin
                fd_next[c] = sat_state(t_reg + sd_ext);
                sd_next[c] = sat_state(u_reg - sp_ext);
            end
        end
    end

    // output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign y_out           = out_reg;

    // control state, coefficients and delays
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            b0_reg        <= COEF_BITS'(1) << COEF_FRAC_BITS;
            b1_reg        <= '0;
            b2_reg        <= '0;
            a1_reg        <= '0;
            a2_reg        <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                fd_reg[c] <= '0;
                sd_reg[c] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            b0_reg        <= b0_next;
            b1_reg        <= b1_next;
            b2_reg        <= b2_next;
            a1_reg        <= a1_next;
            a2_reg        <= a2_next;
            fd_reg        <= fd_next;
            sd_reg        <= sd_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        y_reg    <= y_next;
        t_reg    <= t_next;
        u_reg    <= u_next;
        x_reg    <= x_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

/* src/stereo_biquad_df2t_top.sv */
// ----------------------------------------------------------------------------
// stereo_biquad_df2t_top: stereo second-order IIR section, transposed form
// Both channels of a frame run in turn through six steps each on one 32xN
// multiplier; a hand-over state, held while the output is occupied, then loads
// the output register, and a new frame is taken only back in the idle state.
// Reset clears the delays, sets b0 to unity, other coefficients to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_biquad_df2t_top #(
    parameter int SAMPLE_BITS    = sbq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [sbq_pkg::IDX_W-1:0]     wr_index,
    input  logic [sbq_pkg::COEF_BITS-1:0] wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);
    import sbq_pkg::*;

    cmd_t                          cmd;
    status_t                       status;
    logic signed [SAMPLE_BITS-1:0] x_arr [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] y_arr [CHANNELS];

    // map the stereo ports onto channel words
    assign x_arr[0]  = left_in;
    assign x_arr[1]  = right_in;
    assign left_out  = y_arr[0];
    assign right_out = y_arr[1];

    sbq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sbq_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .x_in      (x_arr),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .y_out     (y_arr)
    );

    // busy after taking a frame
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready after a frame was taken");

    // never overwrite a word that waits at the output
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register loaded while occupied");

    // output words come only from the hand-over step
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("out_valid rose without a load");

    // delay update follows the last feedback product
    a_update_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.state_write |-> $past(cmd.t_sub))
        else $error("delay update out of sequence");

endmodule

/* dv/stereo_biquad_df2t_top_tb.sv */
// ----------------------------------------------------------------------------
// stereo_biquad_df2t_top_tb: self-checking bench for the stereo biquad
// Runs a directed table of frames and coefficient writes, then randomised
// phases of frames under varied coefficient sets, with random idling on both
// handshakes and a long receiver hold-off. Output words are checked against a
// fixed-point transposed form II predictor or the checked table rows' values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_biquad_df2t_top_tb;

    import sbq_pkg::*;

    // formats, matching the block's default parameters
    localparam int SB        = SAMPLE_BITS_DEF;
    localparam int CFB       = COEF_FRAC_BITS_DEF;
    localparam int SFB       = STATE_BITS - 3 - SB;
    localparam int DROP_BITS = CFB - SFB;

    localparam longint SMP_MAX = (64'sd1 <<< (SB - 1)) - 1;
    localparam longint SMP_MIN = -SMP_MAX - 1;
    localparam longint DLY_MAX = (64'sd1 <<< (STATE_BITS - 1)) - 1;
    localparam longint DLY_MIN = -DLY_MAX - 1;

    localparam logic signed [SB-1:0] SMAX_V = 24'sh7FFFFF;
    localparam logic signed [SB-1:0] SMIN_V = 24'sh800000;

    localparam logic [COEF_BITS-1:0] COEF_MIN   = 32'h8000_0000;
    localparam logic [COEF_BITS-1:0] COEF_MAX   = 32'h7FFF_FFFF;
    localparam logic [COEF_BITS-1:0] COEF_UNITY = 32'h4000_0000;
    localparam logic [COEF_BITS-1:0] COEF_ZERO  = 32'h0000_0000;

    // indexes past the last register: writes there are ignored
    localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam int CLK_HALF        = 2;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int HOLD_PHASE      = 1;
    localparam int STEADY_PHASE    = 3;

    typedef enum logic [1:0] {ROW_WRITE, ROW_FRAME, ROW_CHECKED} row_kind_t;
    typedef enum {STYLE_TYPICAL, STYLE_WILD, STYLE_EXTREME} coef_style_t;

    typedef struct packed {
        logic signed [SB-1:0] l;
        logic signed [SB-1:0] r;
    } stereo_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [IDX_W-1:0]     idx;
        logic [COEF_BITS-1:0] data;
        logic signed [SB-1:0] l_smp;
        logic signed [SB-1:0] r_smp;
        logic signed [SB-1:0] want_l;
        logic signed [SB-1:0] want_r;
    } plan_row_t;

    localparam int N_ROWS = 22;

    // directed table: pass-through after reset, b0 at -2.0 with saturation,
    // b0 near +2.0, every coefficient at an extreme, ignored spare indexes
    localparam plan_row_t PLAN [N_ROWS] = '{
        '{ROW_CHECKED, REG_COEF_B0, COEF_ZERO, SMAX_V, SMIN_V, SMAX_V, SMIN_V},
        '{ROW_CHECKED, REG_COEF_B0, COEF_ZERO, 24'sh000000, 24'shFFFFFF,
          24'sh000000, 24'shFFFFFF},
        '{ROW_CHECKED, REG_COEF_B0, COEF_ZERO, 24'sh555555, 24'shAAAAAA,
          24'sh555555, 24'shAAAAAA},
        '{ROW_WRITE,   REG_COEF_B0, COEF_MIN,  24'sh0, 24'sh0, 24'sh0, 24'sh0},
        '{ROW_CHECKED, REG_COEF_B0, COEF_ZERO, SMAX_V, SMIN_V, SMIN_V, SMAX_V},
        '{ROW_CHECKED, REG_COEF_B0, COEF_ZERO, 24'sh000001, 24'shFFFFFF,
          24'shFFFFFE, 24'sh000002},
        '{ROW_CHECKED, REG_COEF_B0, COEF_ZERO, 24'sh0, 24'sh0, 24'sh0, 24'sh0},
        '{ROW_WRITE,   REG_COEF_B0, COEF_MAX,  24'sh0, 24'sh0, 24'sh0, 24'sh0},
        '{ROW_FRAME,   REG_COEF_B0, COEF_ZERO, 24'sh000001, 24'shFFFFFF,
          24'sh0, 24'sh0},
        '{ROW_FRAME,   REG_COEF_B0, COEF_ZERO, SMAX_V, SMIN_V, 24'sh0, 24'sh0},
        '{ROW_WRITE,   REG_COEF_B1, COEF_MAX,  24'sh0, 24'sh0, 24'sh0, 24'sh0},
        '{ROW_WRITE,   REG_COEF_B2, COEF_MIN,  24'sh0, 24'sh0, 24'sh0, 24'sh0},
        '{ROW_WRITE,   REG_COEF_A1, COEF_MIN,  24'sh0, 24'sh0, 24'sh0, 24'sh0},
        '{ROW_WRITE,   REG_COEF_A2, COEF_MAX,  24'sh0, 24'sh0, 24'sh0, 24'sh0},
        '{ROW_FRAME,   REG_COEF_B0, COEF_ZERO, SMAX_V, SMIN_V, 24'sh0, 24'sh0},
        '{ROW_FRAME,   REG_COEF_B0, COEF_ZERO, SMAX_V, SMIN_V, 24'sh0, 24'sh0},
        '{ROW_FRAME,   REG_COEF_B0, COEF_ZERO, SMIN_V, SMAX_V, 24'sh0, 24'sh0},
        '{ROW_FRAME,   REG_COEF_B0, COEF_ZERO, 24'sh0, 24'sh0, 24'sh0, 24'sh0},
        '{ROW_WRITE,   IDX_SPARE_LO, COEF_ZERO, 24'sh0, 24'sh0, 24'sh0, 24'sh0},
        '{ROW_WRITE,   IDX_SPARE_HI, 32'hFFFF_FFFF, 24'sh0, 24'sh0, 24'sh0, 24'sh0},
        '{ROW_FRAME,   REG_COEF_B0, COEF_ZERO, 24'sh000001, 24'shFFFFFF,
          24'sh0, 24'sh0},
        '{ROW_FRAME,   REG_COEF_B0, COEF_ZERO, SMAX_V, 24'sh0, 24'sh0, 24'sh0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_index;
    logic [COEF_BITS-1:0]   wr_data;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [SB-1:0]   left_in;
    logic signed [SB-1:0]   right_in;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [SB-1:0]   left_out;
    logic signed [SB-1:0]   right_out;

    bit      source_steady;
    bit      sink_steady;
    bit      hold_request;
    int      fail_count;
    int      cycle_count;
    stereo_t expected_frames [$];

    // filter state and coefficients as the block should hold them
    longint ff0, ff1, ff2, fb1, fb2;
    longint z1 [CHANNELS];
    longint z2 [CHANNELS];

    stereo_biquad_df2t_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_delay(longint v);
        if (v > DLY_MAX)
            return DLY_MAX;
        if (v < DLY_MIN)
            return DLY_MIN;
        return v;
    endfunction

    // coefficient times sample, rounded half up into delay scaling
    function automatic longint scale_product(longint coef, longint smp);
        longint prod;
        prod = coef * smp;
        return (prod + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS;
    endfunction

    // one channel through the section; advances that channel's delays
    function automatic logic signed [SB-1:0] biquad_sample(int ch,
                                                           logic signed [SB-1:0] x_in);
        longint x;
        longint acc;
        longint y;
        x   = x_in;
        acc = clamp_delay(scale_product(ff0, x) + z1[ch]);
        y   = (acc + (64'sd1 <<< (SFB - 1))) >>> SFB;
        if (y > SMP_MAX)
            y = SMP_MAX;
        else if (y < SMP_MIN)
            y = SMP_MIN;
        // feedback uses the saturated output sample
        z1[ch] = clamp_delay(scale_product(ff1, x) - scale_product(fb1, y) + z2[ch]);
        z2[ch] = clamp_delay(scale_product(ff2, x) - scale_product(fb2, y));
        return y[SB-1:0];
    endfunction

    function automatic void reset_predictor();
        ff0 = 64'sd1 <<< CFB;
        ff1 = 0;
        ff2 = 0;
        fb1 = 0;
        fb2 = 0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            z1[c] = 0;
            z2[c] = 0;
        end
    endfunction

    function automatic void apply_coef_write(logic [IDX_W-1:0] idx,
                                             logic [COEF_BITS-1:0] val);
        longint v;
        v = longint'($signed(val));
        case (idx)
            REG_COEF_B0: ff0 = v;
            REG_COEF_B1: ff1 = v;
            REG_COEF_B2: ff2 = v;
            REG_COEF_A1: fb1 = v;
            REG_COEF_A2: fb2 = v;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic signed [SB-1:0] pick_sample();
        int unsigned roll;
        logic [31:0] raw;
        roll = $urandom_range(0, 9);
        raw  = $urandom;
        case (roll)
            0: return SMAX_V;
            1: return SMIN_V;
            2: return {{(SB - 8){raw[7]}}, raw[7:0]};
            default: return raw[SB-1:0];
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] pick_coef(coef_style_t style, cfg_idx_t which);
        logic [COEF_BITS-1:0] span;
        span = $urandom_range(0, 32'h2000_0000);
        if (style == STYLE_WILD)
            return $urandom;
        if (style == STYLE_EXTREME)
        begin
            case ($urandom_range(0, 3))
                0: return COEF_MIN;
                1: return COEF_MAX;
                2: return COEF_UNITY;
                default: return COEF_ZERO;
            endcase
        end
        // a roughly low-pass shape with poles near the unit circle
        case (which)
            REG_COEF_A1: return COEF_ZERO - (COEF_UNITY + span);
            REG_COEF_A2: return 32'h1000_0000 + span;
            default: return span - 32'h1000_0000;
        endcase
    endfunction

    // offer one frame, hold it until accepted, then record what it should give
    task automatic send_frame(input logic signed [SB-1:0] l_smp,
                              input logic signed [SB-1:0] r_smp,
                              input bit typed, input stereo_t typed_want);
        int      gap;
        stereo_t want;
        @(negedge clk);
        if (!source_steady && $urandom_range(0, 99) < 20)
        begin
            gap = $urandom_range(1, 16);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        left_in  = l_smp;
        right_in = r_smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want.l = biquad_sample(0, l_smp);
        want.r = biquad_sample(1, r_smp);
        expected_frames.push_back(typed ? typed_want : want);
    endtask

    // drop valid and let every pending word come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [COEF_BITS-1:0] val);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = val;
        @(negedge clk);
        wr_en = 1'b0;
        apply_coef_write(idx, val);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, steady stretches, one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : sink_proc
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (sink_steady)
                out_ready = 1'b1;
            else
                out_ready = ($urandom_range(0, 99) >= 20);
        end
    end

    // ------------------------------------------------------------------
    // output check against the oldest pending frame
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_output
        stereo_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("output word with no frame pending: left_out=%0d right_out=%0d",
                       left_out, right_out);
                fail_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                if (left_out !== want.l)
                begin
                    $error("left_out mismatch: expected %0d, actual %0d", want.l, left_out);
                    fail_count++;
                end
                if (right_out !== want.r)
                begin
                    $error("right_out mismatch: expected %0d, actual %0d", want.r, right_out);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stereo_t     typed_want;
        coef_style_t style;
        rst_n         = 1'b0;
        wr_en         = 1'b0;
        wr_index      = '0;
        wr_data       = '0;
        in_valid      = 1'b0;
        left_in       = '0;
        right_in      = '0;
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        hold_request  = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        reset_predictor();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // walk the directed table
        for (int i = 0; i < N_ROWS; i++)
        begin
            typed_want.l = PLAN[i].want_l;
            typed_want.r = PLAN[i].want_r;
            case (PLAN[i].kind)
                ROW_WRITE:
                begin
                    wait_drained();
                    write_coef(PLAN[i].idx, PLAN[i].data);
                end
                ROW_FRAME:   send_frame(PLAN[i].l_smp, PLAN[i].r_smp, 1'b0, typed_want);
                default:     send_frame(PLAN[i].l_smp, PLAN[i].r_smp, 1'b1, typed_want);
            endcase
        end

        // random phases, each under a fresh coefficient set
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            wait_drained();
            style = coef_style_t'(phase % 3);
            write_coef(REG_COEF_B0, pick_coef(style, REG_COEF_B0));
            write_coef(REG_COEF_B1, pick_coef(style, REG_COEF_B1));
            write_coef(REG_COEF_B2, pick_coef(style, REG_COEF_B2));
            write_coef(REG_COEF_A1, pick_coef(style, REG_COEF_A1));
            write_coef(REG_COEF_A2, pick_coef(style, REG_COEF_A2));
            if ($urandom_range(0, 1))
                write_coef($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI, $urandom);
            source_steady = (phase == STEADY_PHASE);
            sink_steady   = (phase == STEADY_PHASE);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_frame(pick_sample(), pick_sample(), 1'b0, typed_want);
                // stall the receiver while frames keep coming
                if (phase == HOLD_PHASE && n == 30)
                    hold_request = 1'b1;
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
src/sbq_pkg.sv
src/sbq_ctrl.sv
src/sbq_datapath.sv
src/stereo_biquad_df2t_top.sv
dv/stereo_biquad_df2t_top_tb.sv
